// ----- hdl/bsp_pkg.sv -----
// Shared types and constants for the brush stroke painter.
// Used by bsp_ctrl, bsp_dpath and brush_stroke_painter; depends on nothing.
`default_nettype none

package bsp_pkg;

	// canvas geometry
	localparam int MAX_WIDTH  = 512;
	localparam int MAX_HEIGHT = 512;
	localparam int MAX_BRUSH  = 16;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SPAN_W     = $clog2(MAX_WIDTH + 1);

	// field widths
	localparam int POS_W      = 11;
	localparam int DELTA_W    = 9;
	localparam int MAG_W      = 9;
	localparam int COLOR_W    = 32;
	localparam int DIM_W      = 10;
	localparam int BSZ_W      = 5;
	localparam int CRD_W      = 13;
	localparam int OFS_W      = BSZ_W + 1;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam logic [COLOR_W-1:0] WHITE       = 32'hFFFF_FFFF;
	localparam logic [DIM_W-1:0]   RESET_DIM   = 10'd500;
	localparam logic [BSZ_W-1:0]   RESET_BRUSH = 5'd5;

	localparam logic OP_PAINT = 1'b0;
	localparam logic OP_READ  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BRUSH  = 2'd2;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_READ_WAIT,
		ST_STAMP,
		ST_ROW,
		ST_PAINT,
		ST_ROW_NEXT,
		ST_STEP,
		ST_RESP
	} bsp_state_t;

	typedef struct packed {
		logic clr;       // write white at the sweep address, advance sweep
		logic load;      // capture the input word
		logic rd;        // issue the pixel read
		logic row_init;  // start the stamp at its top row
		logic row_setup; // latch the clipped span of the current row
		logic paint;     // write one pixel, advance column
		logic row_inc;   // advance to the next row of the stamp
		logic step;      // move the cursor one step along the deltas
		logic out_load;  // load the result register
	} bsp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic op_read;
		logic center_in;
		logic row_ok;
		logic paint_last;
		logic row_last;
		logic walk_done;
		logic out_free;
	} bsp_sts_t;

endpackage

`default_nettype wire

// ----- hdl/bsp_ctrl.sv -----
// Controller state machine of the brush stroke painter.
// Depends on bsp_pkg; drives bsp_dpath through bsp_cmd_t and reads bsp_sts_t.
`default_nettype none

module bsp_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  bsp_pkg::bsp_sts_t sts,
	output bsp_pkg::bsp_cmd_t cmd
);
	import bsp_pkg::*;

	bsp_state_t state_q;
	bsp_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (sts.clear_done) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nx = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				state_nx = sts.op_read ? ST_READ_WAIT : ST_STAMP;
			end
			ST_READ_WAIT: begin
				state_nx = ST_RESP;
			end
			ST_STAMP: begin
				state_nx = sts.center_in ? ST_ROW : ST_STEP;
			end
			ST_ROW: begin
				state_nx = sts.row_ok ? ST_PAINT : ST_ROW_NEXT;
			end
			ST_PAINT: begin
				if (sts.paint_last) state_nx = ST_ROW_NEXT;
			end
			ST_ROW_NEXT: begin
				state_nx = sts.row_last ? ST_STEP : ST_ROW;
			end
			ST_STEP: begin
				state_nx = sts.walk_done ? ST_RESP : ST_STAMP;
			end
			ST_RESP: begin
				if (sts.out_free) state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_DISPATCH: begin
				cmd.rd = sts.op_read;
			end
			ST_STAMP: begin
				cmd.row_init = sts.center_in;
			end
			ST_ROW: begin
				cmd.row_setup = 1'b1;
			end
			ST_PAINT: begin
				cmd.paint = 1'b1;
			end
			ST_ROW_NEXT: begin
				cmd.row_inc = !sts.row_last;
			end
			ST_STEP: begin
				cmd.step = !sts.walk_done;
			end
			ST_RESP: begin
				cmd.out_load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hdl/bsp_dpath.sv -----
// Datapath of the brush stroke painter: config registers, cursor and span
// counters, canvas memory and result register. Depends on bsp_pkg.
`default_nettype none

module bsp_dpath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bsp_pkg::bsp_cmd_t                      cmd,
	output bsp_pkg::bsp_sts_t                      sts,
	input  logic                                   cfg_we,
	input  logic [bsp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [bsp_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   op,
	input  logic signed [bsp_pkg::POS_W-1:0]       pos_x,
	input  logic signed [bsp_pkg::POS_W-1:0]       pos_y,
	input  logic signed [bsp_pkg::DELTA_W-1:0]     delta_x,
	input  logic signed [bsp_pkg::DELTA_W-1:0]     delta_y,
	input  logic [bsp_pkg::COLOR_W-1:0]            paint_color,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [bsp_pkg::COLOR_W-1:0]            pixel_value,
	output logic                                   inside_canvas
);
	import bsp_pkg::*;

	// configuration, saturated on write
	logic [DIM_W-1:0] w_q;
	logic [DIM_W-1:0] h_q;
	logic [BSZ_W-1:0] b_q;

	logic [DIM_W-1:0] w_sat;
	logic [DIM_W-1:0] h_sat;
	logic [BSZ_W-1:0] b_sat;

	always_comb begin
		w_sat = cfg_data;
		if (cfg_data == '0) w_sat = DIM_W'(1);
		else if (cfg_data > DIM_W'(MAX_WIDTH)) w_sat = DIM_W'(MAX_WIDTH);
		h_sat = cfg_data;
		if (cfg_data == '0) h_sat = DIM_W'(1);
		else if (cfg_data > DIM_W'(MAX_HEIGHT)) h_sat = DIM_W'(MAX_HEIGHT);
		b_sat = cfg_data[BSZ_W-1:0];
		if (b_sat == '0) b_sat = BSZ_W'(1);
		else if (b_sat > BSZ_W'(MAX_BRUSH)) b_sat = BSZ_W'(MAX_BRUSH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= RESET_DIM;
			h_q <= RESET_DIM;
			b_q <= RESET_BRUSH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  w_q <= w_sat;
				REG_HEIGHT: h_q <= h_sat;
				REG_BRUSH:  b_q <= b_sat;
				default:    ;
			endcase
		end
	end

	// clearing sweep
	logic [ADDR_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// captured item and walk state
	logic                     op_q;
	logic signed [CRD_W-1:0]  x_q;
	logic signed [CRD_W-1:0]  y_q;
	logic [MAG_W-1:0]         sx_q;
	logic [MAG_W-1:0]         sy_q;
	logic                     dxneg_q;
	logic                     dyneg_q;
	logic [COLOR_W-1:0]       color_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			x_q     <= CRD_W'(pos_x);
			y_q     <= CRD_W'(pos_y);
			sx_q    <= delta_x[DELTA_W-1] ? MAG_W'(-delta_x) : MAG_W'(delta_x);
			sy_q    <= delta_y[DELTA_W-1] ? MAG_W'(-delta_y) : MAG_W'(delta_y);
			dxneg_q <= delta_x[DELTA_W-1];
			dyneg_q <= delta_y[DELTA_W-1];
			color_q <= paint_color;
		end else if (cmd.step) begin
			if (sx_q != '0) begin
				x_q  <= dxneg_q ? x_q - CRD_W'(1) : x_q + CRD_W'(1);
				sx_q <= sx_q - MAG_W'(1);
			end
			// positive delta_y moves up, so the row decreases
			if (sy_q != '0) begin
				y_q  <= dyneg_q ? y_q + CRD_W'(1) : y_q - CRD_W'(1);
				sy_q <= sy_q - MAG_W'(1);
			end
		end
	end

	logic signed [CRD_W-1:0] wc;
	logic signed [CRD_W-1:0] hc;
	assign wc = signed'(CRD_W'(w_q));
	assign hc = signed'(CRD_W'(h_q));

	// stamp rows run from -imax to +imax around the center
	logic [BSZ_W-1:0]        imax;
	logic signed [OFS_W-1:0] imax_s;
	assign imax   = (b_q >= BSZ_W'(2)) ? b_q - BSZ_W'(2) : '0;
	assign imax_s = signed'(OFS_W'(imax));

	logic signed [OFS_W-1:0] i_q;
	logic [ROW_W-1:0]        row_q;
	logic [SPAN_W-1:0]       col_q;
	logic [SPAN_W-1:0]       hi_q;

	logic [OFS_W-1:0]        abs_i;
	logic signed [CRD_W-1:0] row_c;
	logic signed [CRD_W-1:0] half;
	logic signed [CRD_W-1:0] lo_r;
	logic signed [CRD_W-1:0] hi_r;
	logic signed [CRD_W-1:0] lo_c;
	logic signed [CRD_W-1:0] hi_c;

	always_comb begin
		abs_i = i_q[OFS_W-1] ? OFS_W'(-i_q) : OFS_W'(i_q);
		row_c = y_q + CRD_W'(i_q);
		half  = signed'(CRD_W'(b_q) - CRD_W'(abs_i));
		if (b_q == BSZ_W'(1)) begin
			lo_r = x_q;
			hi_r = x_q + CRD_W'(1);
		end else begin
			lo_r = x_q - half;
			hi_r = x_q + half;
		end
		lo_c = lo_r[CRD_W-1] ? '0 : lo_r;
		hi_c = (hi_r > wc) ? wc : hi_r;
	end

	always_ff @(posedge clk) begin
		if (cmd.row_init) begin
			i_q <= -imax_s;
		end else if (cmd.row_inc) begin
			i_q <= i_q + OFS_W'(1);
		end
		if (cmd.row_setup) begin
			row_q <= row_c[ROW_W-1:0];
			col_q <= lo_c[SPAN_W-1:0];
			hi_q  <= hi_c[SPAN_W-1:0];
		end else if (cmd.paint) begin
			col_q <= col_q + SPAN_W'(1);
		end
	end

	// canvas memory, single port
	logic [COLOR_W-1:0] mem [DEPTH];
	logic [COLOR_W-1:0] rdata_q;
	logic [ADDR_W-1:0]  paint_addr;
	logic [ADDR_W-1:0]  read_addr;
	logic [ADDR_W-1:0]  mem_addr;
	logic [COLOR_W-1:0] mem_wdata;
	logic               mem_we;

	assign paint_addr = ADDR_W'(row_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(col_q[COL_W-1:0]);
	assign read_addr  = ADDR_W'(y_q[ROW_W-1:0]) * ADDR_W'(MAX_WIDTH)
		+ ADDR_W'(x_q[COL_W-1:0]);
	assign mem_we     = cmd.clr | cmd.paint;
	assign mem_wdata  = cmd.clr ? WHITE : color_q;
	assign mem_addr   = cmd.clr ? clr_q : (cmd.paint ? paint_addr : read_addr);

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= mem_wdata;
		if (cmd.rd) rdata_q <= mem[mem_addr];
	end

	// result register
	logic               out_valid_q;
	logic [COLOR_W-1:0] pixel_q;
	logic               inside_q;
	logic               center_in;
	logic               rd_hit;

	assign center_in = (x_q >= 0) && (y_q >= 0) && (x_q < wc) && (y_q < hc);
	assign rd_hit    = (op_q == OP_READ) && center_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			pixel_q  <= rd_hit ? rdata_q : '0;
			inside_q <= rd_hit;
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_value   = pixel_q;
	assign inside_canvas = inside_q;

	always_comb begin
		sts.clear_done = (clr_q == ADDR_W'(DEPTH - 1));
		sts.op_read    = (op_q == OP_READ);
		sts.center_in  = center_in;
		sts.row_ok     = (row_c >= 0) && (row_c < hc) && (lo_c < hi_c);
		sts.paint_last = ((col_q + SPAN_W'(1)) == hi_q);
		sts.row_last   = (i_q == imax_s);
		sts.walk_done  = (sx_q == '0) && (sy_q == '0);
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

`default_nettype wire

// ----- hdl/brush_stroke_painter.sv -----
// Brush stroke painter: a read passes dispatch, read wait and result load; a
// stroke stamps each inside cursor position row by row, one pixel at a time.
// One word at a time: the next is taken the cycle after the result loads, and
// the result waits while the previous result word is still unaccepted.
// After reset a sweep writes white to all 262144 pixels, one per cycle, and no
// input word is accepted until it ends; config writes are taken meanwhile.
`default_nettype none

module brush_stroke_painter (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [bsp_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [bsp_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   op,
	input  logic signed [bsp_pkg::POS_W-1:0]       pos_x,
	input  logic signed [bsp_pkg::POS_W-1:0]       pos_y,
	input  logic signed [bsp_pkg::DELTA_W-1:0]     delta_x,
	input  logic signed [bsp_pkg::DELTA_W-1:0]     delta_y,
	input  logic [bsp_pkg::COLOR_W-1:0]            paint_color,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [bsp_pkg::COLOR_W-1:0]            pixel_value,
	output logic                                   inside_canvas
);
	import bsp_pkg::*;

	bsp_cmd_t cmd;
	bsp_sts_t sts;

	bsp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bsp_dpath u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.op            (op),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.delta_x       (delta_x),
		.delta_y       (delta_y),
		.paint_color   (paint_color),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.pixel_value   (pixel_value),
		.inside_canvas (inside_canvas)
	);

endmodule

`default_nettype wire
